// ===== sv/turtle_graphics_step_assert.svh =====
// Assertion macros for the turtle step RTL.
`ifndef TURTLE_GRAPHICS_STEP_ASSERT_SVH
`define TURTLE_GRAPHICS_STEP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TGS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tgs_pkg.sv =====
// Types, constants and arithmetic helpers of the turtle step block.
package tgs_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SINE_FRAC_BITS = 14;

    localparam int AMOUNT_W   = 16;
    localparam int HEADING_W  = 9;
    localparam int FIELD_W    = 16;
    localparam int SINE_W     = SINE_FRAC_BITS + 2;
    localparam int PROD_W     = AMOUNT_W + SINE_W;
    localparam int DELTA_W    = PROD_W - SINE_FRAC_BITS;
    localparam int SUM_W      = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 1;
    localparam int COORD_WIDE = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SINE_SHIFT = 30 - SINE_FRAC_BITS;
    localparam int TABLE_LAST = 90;

    localparam logic [HEADING_W-1:0] DEG_QUARTER = 9'd90;
    localparam logic [HEADING_W-1:0] DEG_HALF    = 9'd180;
    localparam logic [HEADING_W-1:0] DEG_3QUART  = 9'd270;
    localparam logic [HEADING_W-1:0] DEG_FULL    = 9'd360;

    // amount mod 360 via reciprocal multiply on the biased amount
    localparam int MOD_SHIFT              = 26;
    localparam int MOD_BIAS_W             = AMOUNT_W + 1;
    localparam int MOD_RECIP_W            = 18;
    localparam int MOD_PROD_W             = MOD_BIAS_W + MOD_RECIP_W;
    localparam int MOD_QUOT_W             = 8;
    localparam logic [MOD_RECIP_W-1:0] MOD_RECIP = MOD_RECIP_W'(((1 << MOD_SHIFT) + 359) / 360);
    localparam logic signed [MOD_BIAS_W:0] MOD_BIAS = 18'sd33120;

    localparam logic signed [COORD_BITS-1:0] RESET_X = COORD_BITS'(320);
    localparam logic signed [COORD_BITS-1:0] RESET_Y = COORD_BITS'(240);
    localparam logic [7:0]                   RESET_PEN_COLOR = 8'd1;

    localparam logic signed [SUM_W-1:0] SUM_COORD_MAX =
        SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_COORD_MIN = -SUM_COORD_MAX - SUM_W'(1);
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
        PROD_W'((64'sd1 <<< SINE_FRAC_BITS) - 64'sd1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TERM_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [2:0] {
        FUNC_FORWARD  = 3'd0,
        FUNC_RIGHT    = 3'd1,
        FUNC_LEFT     = 3'd2,
        FUNC_PEN_UP   = 3'd3,
        FUNC_PEN_DOWN = 3'd4,
        FUNC_HOME     = 3'd5,
        FUNC_CLEAR    = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        CFG_HOME_X    = 2'd0,
        CFG_HOME_Y    = 2'd1,
        CFG_PEN_COLOR = 2'd2
    } cfg_index_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [TABLE_LAST:0][SINE_W-1:0] sine_table_t;

    typedef struct packed {
        func_t                        func;
        logic signed [AMOUNT_W-1:0]   amount;
        logic [HEADING_W-1:0]         amount_mod;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   from_x;
        logic [FIELD_W-1:0]   from_y;
        logic [FIELD_W-1:0]   to_x;
        logic [FIELD_W-1:0]   to_y;
        logic [HEADING_W-1:0] heading_out;
        logic                 pen_is_down;
        logic                 draw_line;
        logic [7:0]           line_color;
        logic                 clear_screen;
    } result_t;

    // Q30 power series per whole degree of the first quadrant, rounded half up
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        tbl = '0;
        for (int d = 0; d <= TABLE_LAST; d++)
        begin
            x    = (64'(d) * PI_Q30) / 64'd180;
            sum  = x;
            term = x;
            for (int k = 1; k <= 10; k++)
            begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / TERM_DIV[k];
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            tbl[d] = SINE_W'((sum + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    // fold a heading 0..359 into the quadrant table
    function automatic logic signed [SINE_W-1:0] sine_of(input logic [HEADING_W-1:0] deg);
        logic [HEADING_W-1:0]    r;
        logic [6:0]              idx;
        logic                    neg;
        logic signed [SINE_W-1:0] mag;
        if (deg >= DEG_3QUART)
        begin
            r   = deg - DEG_3QUART;
            idx = 7'(DEG_QUARTER - r);
            neg = 1'b1;
        end
        else if (deg >= DEG_HALF)
        begin
            r   = deg - DEG_HALF;
            idx = 7'(r);
            neg = 1'b1;
        end
        else if (deg >= DEG_QUARTER)
        begin
            r   = DEG_HALF - deg;
            idx = 7'(r);
            neg = 1'b0;
        end
        else
        begin
            r   = deg;
            idx = 7'(r);
            neg = 1'b0;
        end
        mag = $signed(SINE_TABLE[idx]);
        return neg ? -mag : mag;
    endfunction

    // amount * sine / 2^F, truncated toward zero
    function automatic logic signed [DELTA_W-1:0] scaled(
        input logic signed [AMOUNT_W-1:0] amount,
        input logic signed [SINE_W-1:0]   sine
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(amount) * PROD_W'(sine);
        if (p < 0)
            p = p + TRUNC_BIAS;
        return DELTA_W'(p >>> SINE_FRAC_BITS);
    endfunction

    function automatic coord_t clamp_coord(input logic signed [SUM_W-1:0] v);
        if (v > SUM_COORD_MAX)
            return COORD_BITS'(SUM_COORD_MAX);
        else if (v < SUM_COORD_MIN)
            return COORD_BITS'(SUM_COORD_MIN);
        else
            return COORD_BITS'(v);
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input coord_t v);
        logic signed [COORD_WIDE-1:0] w;
        w = COORD_WIDE'(v);
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== sv/tgs_in_stage.sv =====
// Input register of the turtle step block, with amount reduced modulo 360.
module tgs_in_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [2:0]                     func,
    input  logic signed [tgs_pkg::AMOUNT_W-1:0] amount,
    input  logic                           take,
    output logic                           item_vld,
    output tgs_pkg::item_t                 item
);

    logic                                   vld_reg;
    tgs_pkg::item_t                         item_reg;
    tgs_pkg::item_t                         item_next;
    logic signed [tgs_pkg::MOD_BIAS_W:0]    amt_wide;
    logic [tgs_pkg::MOD_BIAS_W-1:0]         amt_bias;
    logic [tgs_pkg::MOD_PROD_W-1:0]         mod_prod;
    logic [tgs_pkg::MOD_QUOT_W-1:0]         mod_quot;
    logic [tgs_pkg::MOD_BIAS_W-1:0]         mod_back;

    // bias by a multiple of 360 so the reduction works on a positive value
    always_comb
    begin
        amt_wide = (tgs_pkg::MOD_BIAS_W + 1)'(amount) + tgs_pkg::MOD_BIAS;
        amt_bias = tgs_pkg::MOD_BIAS_W'(amt_wide);
        mod_prod = tgs_pkg::MOD_PROD_W'(amt_bias) * tgs_pkg::MOD_PROD_W'(tgs_pkg::MOD_RECIP);
        mod_quot = tgs_pkg::MOD_QUOT_W'(mod_prod >> tgs_pkg::MOD_SHIFT);
        mod_back = tgs_pkg::MOD_BIAS_W'(mod_quot) * tgs_pkg::MOD_BIAS_W'(tgs_pkg::DEG_FULL);
        item_next.func       = tgs_pkg::func_t'(func);
        item_next.amount     = amount;
        item_next.amount_mod = tgs_pkg::HEADING_W'(amt_bias - mod_back);
    end

    assign s_tready = !vld_reg || take;
    assign item_vld = vld_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            vld_reg <= 1'b1;
        else if (take)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_next;
    end

endmodule

// ===== sv/tgs_core.sv =====
// Turtle state, configuration registers, command datapath and result register.
module tgs_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                item_vld,
    input  tgs_pkg::item_t      item,
    output logic                take,
    output logic                out_vld,
    input  logic                out_ready,
    output tgs_pkg::result_t    result
);

    logic signed [15:0]                      home_x_reg;
    logic signed [15:0]                      home_y_reg;
    logic [7:0]                              pen_color_reg;
    tgs_pkg::coord_t                         pos_x_reg;
    tgs_pkg::coord_t                         pos_y_reg;
    tgs_pkg::coord_t                         pos_x_next;
    tgs_pkg::coord_t                         pos_y_next;
    logic [tgs_pkg::HEADING_W-1:0]           heading_reg;
    logic [tgs_pkg::HEADING_W-1:0]           heading_next;
    logic                                    pen_reg;
    logic                                    pen_next;
    logic                                    out_vld_reg;
    tgs_pkg::result_t                        result_reg;
    tgs_pkg::result_t                        result_next;
    logic [tgs_pkg::HEADING_W-1:0]           cos_angle;
    logic signed [tgs_pkg::SINE_W-1:0]       sin_h;
    logic signed [tgs_pkg::SINE_W-1:0]       cos_h;
    logic signed [tgs_pkg::DELTA_W-1:0]      dx;
    logic signed [tgs_pkg::DELTA_W-1:0]      dy;
    logic signed [tgs_pkg::SUM_W-1:0]        sum_x;
    logic signed [tgs_pkg::SUM_W-1:0]        sum_y;
    logic [tgs_pkg::HEADING_W:0]             turn_r;
    logic signed [tgs_pkg::HEADING_W+1:0]    turn_l;
    logic                                    draw;
    logic                                    clr;

    assign take    = item_vld && (!out_vld_reg || out_ready);
    assign out_vld = out_vld_reg;
    assign result  = result_reg;

    always_comb
    begin
        cos_angle = (heading_reg >= tgs_pkg::DEG_3QUART) ? heading_reg - tgs_pkg::DEG_3QUART
                                                         : heading_reg + tgs_pkg::DEG_QUARTER;
        sin_h = tgs_pkg::sine_of(heading_reg);
        cos_h = tgs_pkg::sine_of(cos_angle);
        dx    = tgs_pkg::scaled(item.amount, sin_h);
        dy    = tgs_pkg::scaled(item.amount, cos_h);
        sum_x = tgs_pkg::SUM_W'(pos_x_reg) + tgs_pkg::SUM_W'(dx);
        sum_y = tgs_pkg::SUM_W'(pos_y_reg) - tgs_pkg::SUM_W'(dy);
        turn_r = (tgs_pkg::HEADING_W + 1)'(heading_reg) + (tgs_pkg::HEADING_W + 1)'(item.amount_mod);
        turn_l = $signed({2'b00, heading_reg}) - $signed({2'b00, item.amount_mod});

        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        pen_next     = pen_reg;
        draw         = 1'b0;
        clr          = 1'b0;

        unique case (item.func) inside
            tgs_pkg::FUNC_FORWARD:
            begin
                pos_x_next = tgs_pkg::clamp_coord(sum_x);
                pos_y_next = tgs_pkg::clamp_coord(sum_y);
                draw       = pen_reg;
            end
            tgs_pkg::FUNC_RIGHT:
            begin
                if (turn_r >= (tgs_pkg::HEADING_W + 1)'(tgs_pkg::DEG_FULL))
                    heading_next = tgs_pkg::HEADING_W'(turn_r - (tgs_pkg::HEADING_W + 1)'(tgs_pkg::DEG_FULL));
                else
                    heading_next = tgs_pkg::HEADING_W'(turn_r);
            end
            tgs_pkg::FUNC_LEFT:
            begin
                if (turn_l < 0)
                    heading_next = tgs_pkg::HEADING_W'(turn_l + $signed({2'b00, tgs_pkg::DEG_FULL}));
                else
                    heading_next = tgs_pkg::HEADING_W'(turn_l);
            end
            tgs_pkg::FUNC_PEN_UP:
                pen_next = 1'b0;
            tgs_pkg::FUNC_PEN_DOWN:
                pen_next = 1'b1;
            tgs_pkg::FUNC_HOME, tgs_pkg::FUNC_CLEAR:
            begin
                pos_x_next   = tgs_pkg::clamp_coord(tgs_pkg::SUM_W'(home_x_reg));
                pos_y_next   = tgs_pkg::clamp_coord(tgs_pkg::SUM_W'(home_y_reg));
                heading_next = '0;
                clr          = (item.func == tgs_pkg::FUNC_CLEAR);
            end
            default:
            begin
                // unused code: report the state unchanged
            end
        endcase

        result_next.from_x       = tgs_pkg::to_field(pos_x_reg);
        result_next.from_y       = tgs_pkg::to_field(pos_y_reg);
        result_next.to_x         = tgs_pkg::to_field(pos_x_next);
        result_next.to_y         = tgs_pkg::to_field(pos_y_next);
        result_next.heading_out  = heading_next;
        result_next.pen_is_down  = pen_next;
        result_next.draw_line    = draw;
        result_next.line_color   = draw ? pen_color_reg : 8'd0;
        result_next.clear_screen = clr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_x_reg    <= 16'sd320;
            home_y_reg    <= 16'sd240;
            pen_color_reg <= tgs_pkg::RESET_PEN_COLOR;
        end
        else if (cfg_we)
        begin
            unique case (tgs_pkg::cfg_index_t'(cfg_index))
                tgs_pkg::CFG_HOME_X:    home_x_reg    <= cfg_wdata;
                tgs_pkg::CFG_HOME_Y:    home_y_reg    <= cfg_wdata;
                tgs_pkg::CFG_PEN_COLOR: pen_color_reg <= cfg_wdata[7:0];
                default:
                begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= tgs_pkg::RESET_X;
            pos_y_reg   <= tgs_pkg::RESET_Y;
            heading_reg <= '0;
            pen_reg     <= 1'b1;
        end
        else if (take)
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            pen_reg     <= pen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (take)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

`include "turtle_graphics_step_assert.svh"

    `TGS_ASSERT_ALWAYS(a_heading_range, heading_reg < tgs_pkg::DEG_FULL, "heading left 0..359")
    `TGS_ASSERT(a_take_fills_output, take |=> out_vld_reg, "taken item did not reach result register")
    `TGS_ASSERT(a_draw_needs_pen, out_vld_reg && result_reg.draw_line |-> result_reg.pen_is_down && !result_reg.clear_screen, "line drawn with pen up or on clear")
    `TGS_ASSERT(a_clear_is_home, out_vld_reg && result_reg.clear_screen |-> result_reg.heading_out == '0 && result_reg.line_color == 8'd0, "clear result not at home heading")

endmodule

// ===== sv/turtle_graphics_step.sv =====
// Turtle step block: one decoded turtle command per item, one result item per command.
//
// Accepts one command item per clock cycle unless the result stalls. The input register
// holds the item and its amount reduced modulo 360 (reciprocal multiply); then two lookups
// in the quadrant sine table, two 16 by 16 multiplies, the position add and clamp, and the
// heading update load the result register and the turtle state together. Back-to-back
// commands see the state left by the one before. A stalled result holds the pipeline;
// the user must write configuration while no item is in flight; the block does not enforce it.
module turtle_graphics_step
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] amount
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // from_x, from_y, to_x, to_y, heading_out, pen_is_down,
                                   // draw_line, line_color, clear_screen, zero pad
);

    logic             take;
    logic             item_vld;
    tgs_pkg::item_t   item;
    tgs_pkg::result_t result;

    tgs_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .amount   (s_tdata),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    tgs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_vld  (item_vld),
        .item      (item),
        .take      (take),
        .out_vld   (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = {4'b0000, result.clear_screen, result.line_color, result.draw_line,
                      result.pen_is_down, result.heading_out, result.to_y, result.to_x,
                      result.from_y, result.from_x};

endmodule
